// ----- src/dset_pkg.sv -----
// Package for the depth-sorted entry table: sizes, codes and shared types.
// Used by the channel interfaces, the controller, the datapath and the checker.
package dset_pkg;

    // Table size and the widths that follow from it.
    localparam int CAPACITY    = 256;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int LINEAR_STOP = 5;

    // Fixed field widths of the channels.
    localparam int OP_W     = 2;
    localparam int ID_W     = 16;
    localparam int DEPTH_W  = 32;
    localparam int IDX_W    = 8;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 9;

    // Operation codes of a request.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT     = 2'd0,
        OP_REMOVE     = 2'd1,
        OP_REPOSITION = 2'd2,
        OP_READ       = 2'd3
    } op_t;

    // Status codes of a response.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_OOB       = 2'd3
    } status_t;

    // One table entry as held in memory.
    typedef struct packed {
        logic [ID_W-1:0]           id;
        logic signed [DEPTH_W-1:0] depth;
    } entry_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RM_SCAN,
        S_RM_SHIFT,
        S_INS_START,
        S_BS_READ,
        S_BS_CMP,
        S_LIN_SCAN,
        S_INS_SHIFT,
        S_RD_START,
        S_RD_WAIT,
        S_FINISH
    } state_t;

    // Datapath actions, one per controller state.
    typedef enum logic [3:0] {
        ACT_ACCEPT,
        ACT_RM_SCAN,
        ACT_RM_SHIFT,
        ACT_INS_START,
        ACT_BS_READ,
        ACT_BS_CMP,
        ACT_LIN_SCAN,
        ACT_INS_SHIFT,
        ACT_RD_START,
        ACT_RD_WAIT,
        ACT_FINISH
    } act_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        act_t act;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_valid;
        op_t  in_op;
        op_t  op;
        logic rm_hit;
        logic cnt_end;
        logic full;
        logic bs_more;
        logic bs_lt;
        logic bs_gt;
        logic lin_hit;
        logic lin_end;
        logic ins_done;
        logic rd_oob;
        logic out_free;
    } dp_status_t;

endpackage

// ----- src/dset_if.sv -----
// Valid/ready channel interfaces for requests and responses of the table.
// Depends on dset_pkg for the field widths.
interface dset_in_if import dset_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic [ID_W-1:0]           item_id;
    logic signed [DEPTH_W-1:0] depth_key;
    logic [IDX_W-1:0]          read_index;

    modport source (output valid, operation, item_id, depth_key, read_index, input ready);
    modport sink (input valid, operation, item_id, depth_key, read_index, output ready);
endinterface

interface dset_out_if import dset_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [POS_W-1:0]          position;
    logic [POS_W-1:0]          entry_count;
    logic [ID_W-1:0]           read_id;
    logic signed [DEPTH_W-1:0] read_depth;

    modport source (output valid, status, position, entry_count, read_id, read_depth,
                    input ready);
    modport sink (input valid, status, position, entry_count, read_id, read_depth,
                  output ready);
endinterface

// ----- src/depth_sorted_entry_table_unit.sv -----
// Depth-sorted entry table: holds up to CAPACITY (id, depth) entries in
// ascending signed Q16.16 depth order in one single-port-read memory, and
// handles one transaction at a time. A read fetches the entry at the index;
// an insert halves the search range with a read and a compare per step
// until it is LINEAR_STOP wide or less, scans it linearly for the first deeper
// entry and shifts the later entries up; a remove scans for the id and shifts
// the later entries down; reposition is a remove followed by an insert. The
// memory port moves one entry per cycle during scans and shifts. A finished
// response waits in an output register while the next request is accepted.
// Depends on dset_pkg and dset_if.
module depth_sorted_entry_table_unit import dset_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dset_in_if.sink    req,
    dset_out_if.source rsp
);

    ctl_cmd_t   cmd;
    dp_status_t stat;

    // Sequencer.
    dset_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Memory, pointers and response register.
    dset_datapath u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// ----- src/dset_ctrl.sv -----
// Controller of the depth-sorted entry table: sequences search, shift and read.
// Depends on dset_pkg; drives the datapath through ctl_cmd_t only.
module dset_ctrl import dset_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t stat,
    output ctl_cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (stat.in_valid)
                begin
                    unique case (stat.in_op)
                        OP_INSERT:     state_next = S_INS_START;
                        OP_REMOVE:     state_next = S_RM_SCAN;
                        OP_REPOSITION: state_next = S_RM_SCAN;
                        OP_READ:       state_next = S_RD_START;
                        default:       state_next = S_IDLE;
                    endcase
                end
            end
            S_RM_SCAN:
            begin
                if (stat.rm_hit)
                begin
                    state_next = S_RM_SHIFT;
                end
                else if (stat.cnt_end)
                begin
                    state_next = (stat.op == OP_REPOSITION) ? S_INS_START : S_FINISH;
                end
            end
            S_RM_SHIFT:
            begin
                if (stat.cnt_end)
                begin
                    state_next = (stat.op == OP_REPOSITION) ? S_INS_START : S_FINISH;
                end
            end
            S_INS_START:
            begin
                state_next = stat.full ? S_FINISH : S_BS_READ;
            end
            S_BS_READ:
            begin
                state_next = stat.bs_more ? S_BS_CMP : S_LIN_SCAN;
            end
            S_BS_CMP:
            begin
                state_next = (!stat.bs_lt && !stat.bs_gt) ? S_INS_SHIFT : S_BS_READ;
            end
            S_LIN_SCAN:
            begin
                if (stat.lin_hit || stat.lin_end)
                begin
                    state_next = S_INS_SHIFT;
                end
            end
            S_INS_SHIFT:
            begin
                if (stat.ins_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_RD_START:
            begin
                state_next = stat.rd_oob ? S_FINISH : S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output decode: one datapath action per state.
    always_comb
    begin
        cmd.in_ready = 1'b0;
        cmd.act      = ACT_FINISH;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.act      = ACT_ACCEPT;
            end
            S_RM_SCAN:   cmd.act = ACT_RM_SCAN;
            S_RM_SHIFT:  cmd.act = ACT_RM_SHIFT;
            S_INS_START: cmd.act = ACT_INS_START;
            S_BS_READ:   cmd.act = ACT_BS_READ;
            S_BS_CMP:    cmd.act = ACT_BS_CMP;
            S_LIN_SCAN:  cmd.act = ACT_LIN_SCAN;
            S_INS_SHIFT: cmd.act = ACT_INS_SHIFT;
            S_RD_START:  cmd.act = ACT_RD_START;
            S_RD_WAIT:   cmd.act = ACT_RD_WAIT;
            S_FINISH:    cmd.act = ACT_FINISH;
            default:     cmd.act = ACT_FINISH;
        endcase
    end

endmodule

// ----- src/dset_datapath.sv -----
// Datapath of the depth-sorted entry table: entry memory, search pointers,
// result staging and the output register. Depends on dset_pkg and dset_if.
module dset_datapath import dset_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  ctl_cmd_t      cmd,
    output dp_status_t    stat,
    dset_in_if.sink       req,
    dset_out_if.source    rsp
);

    localparam int CMP_W = IDX_W + CNT_W;

    // Entry memory: one write port, one registered read port.
    entry_t mem [CAPACITY];

    // Request fields of the transaction in progress.
    op_t                       op_reg, op_next;
    logic [ID_W-1:0]           id_reg, id_next;
    logic signed [DEPTH_W-1:0] key_reg, key_next;
    logic [IDX_W-1:0]          ridx_reg, ridx_next;

    // Table occupancy and search/shift pointers.
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    entry_t            rd_data_reg;

    // Result being built and the output register.
    status_t                   res_status_reg, res_status_next;
    logic [CNT_W-1:0]          res_pos_reg, res_pos_next;
    logic [ID_W-1:0]           res_id_reg, res_id_next;
    logic signed [DEPTH_W-1:0] res_depth_reg, res_depth_next;
    logic                      out_valid_reg, out_valid_next;
    status_t                   out_status_reg, out_status_next;
    logic [CNT_W-1:0]          out_pos_reg, out_pos_next;
    logic [CNT_W-1:0]          out_count_reg, out_count_next;
    logic [ID_W-1:0]           out_id_reg, out_id_next;
    logic signed [DEPTH_W-1:0] out_depth_reg, out_depth_next;

    // Memory port controls.
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              stream_rd;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;

    // Decision signals.
    logic [CNT_W:0]            center_sum;
    logic [ADDR_W-1:0]         center;
    logic [CNT_W-1:0]          span;
    logic signed [DEPTH_W-1:0] rd_depth;
    logic                      accept;
    logic                      out_free;
    logic                      rm_hit;
    logic                      cnt_end;
    logic                      full;
    logic                      bs_more;
    logic                      bs_lt;
    logic                      bs_gt;
    logic                      lin_hit;
    logic                      lin_end;
    logic                      ins_done;
    logic                      rd_oob;

    // Search and scan conditions.
    always_comb
    begin
        center_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
        center     = center_sum[ADDR_W:1];
        span       = hi_reg - lo_reg;
        rd_depth   = rd_data_reg.depth;
        accept     = req.valid && cmd.in_ready;
        out_free   = !out_valid_reg || rsp.ready;
        rm_hit     = pend_reg && (rd_data_reg.id == id_reg);
        cnt_end    = !pend_reg && (ptr_reg >= count_reg);
        full       = count_reg >= CNT_W'(CAPACITY);
        bs_more    = span > CNT_W'(LINEAR_STOP);
        bs_lt      = key_reg < rd_depth;
        bs_gt      = key_reg > rd_depth;
        lin_hit    = pend_reg && (rd_depth > key_reg);
        lin_end    = !pend_reg && (ptr_reg >= hi_reg);
        ins_done   = !pend_reg && (ptr_reg <= pos_reg);
        rd_oob     = CMP_W'(ridx_reg) >= CMP_W'(count_reg);
    end

    // Status to the controller.
    always_comb
    begin
        stat.in_valid = req.valid;
        stat.in_op    = op_t'(req.operation);
        stat.op       = op_reg;
        stat.rm_hit   = rm_hit;
        stat.cnt_end  = cnt_end;
        stat.full     = full;
        stat.bs_more  = bs_more;
        stat.bs_lt    = bs_lt;
        stat.bs_gt    = bs_gt;
        stat.lin_hit  = lin_hit;
        stat.lin_end  = lin_end;
        stat.ins_done = ins_done;
        stat.rd_oob   = rd_oob;
        stat.out_free = out_free;
    end

    // Memory port selection. Streaming reads are tracked by the pending flag
    // so that their data is checked or moved in the next cycle.
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = '0;
        stream_rd = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = rd_data_reg;
        unique case (cmd.act)
            ACT_RM_SCAN:
            begin
                if (!rm_hit && (ptr_reg < count_reg))
                begin
                    rd_en     = 1'b1;
                    stream_rd = 1'b1;
                    rd_addr   = ptr_reg[ADDR_W-1:0];
                end
            end
            ACT_RM_SHIFT:
            begin
                if (ptr_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    stream_rd = 1'b1;
                    rd_addr   = ptr_reg[ADDR_W-1:0];
                end
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pend_addr_reg - ADDR_W'(1);
                end
            end
            ACT_BS_READ:
            begin
                if (bs_more)
                begin
                    rd_en   = 1'b1;
                    rd_addr = center;
                end
            end
            ACT_LIN_SCAN:
            begin
                if (!lin_hit && (ptr_reg < hi_reg))
                begin
                    rd_en     = 1'b1;
                    stream_rd = 1'b1;
                    rd_addr   = ptr_reg[ADDR_W-1:0];
                end
            end
            ACT_INS_SHIFT:
            begin
                if (ptr_reg > pos_reg)
                begin
                    rd_en     = 1'b1;
                    stream_rd = 1'b1;
                    rd_addr   = ADDR_W'(ptr_reg - CNT_W'(1));
                end
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pend_addr_reg + ADDR_W'(1);
                end
                else if (ins_done)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = pos_reg[ADDR_W-1:0];
                    wr_data.id    = id_reg;
                    wr_data.depth = key_reg;
                end
            end
            ACT_RD_START:
            begin
                if (!rd_oob)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ADDR_W'(ridx_reg);
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Memory array.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Next values of pointers, count and result.
    always_comb
    begin
        op_next         = op_reg;
        id_next         = id_reg;
        key_next        = key_reg;
        ridx_next       = ridx_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        ptr_next        = ptr_reg;
        pos_next        = pos_reg;
        pend_next       = stream_rd;
        pend_addr_next  = rd_addr;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_id_next     = res_id_reg;
        res_depth_next  = res_depth_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_count_next  = out_count_reg;
        out_id_next     = out_id_reg;
        out_depth_next  = out_depth_reg;

        unique case (cmd.act)
            ACT_ACCEPT:
            begin
                if (accept)
                begin
                    op_next         = op_t'(req.operation);
                    id_next         = req.item_id;
                    key_next        = req.depth_key;
                    ridx_next       = req.read_index;
                    ptr_next        = '0;
                    res_status_next = ST_OK;
                    res_pos_next    = '0;
                    res_id_next     = '0;
                    res_depth_next  = '0;
                end
            end
            ACT_RM_SCAN:
            begin
                if (rm_hit)
                begin
                    pos_next = CNT_W'(pend_addr_reg);
                    ptr_next = CNT_W'(pend_addr_reg) + CNT_W'(1);
                end
                else if (cnt_end)
                begin
                    res_status_next = ST_NOT_FOUND;
                    res_pos_next    = '0;
                end
                else if (ptr_reg < count_reg)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            ACT_RM_SHIFT:
            begin
                if (ptr_reg < count_reg)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                if (cnt_end)
                begin
                    count_next      = count_reg - CNT_W'(1);
                    res_status_next = ST_OK;
                    res_pos_next    = pos_reg;
                end
            end
            ACT_INS_START:
            begin
                if (full)
                begin
                    res_status_next = ST_FULL;
                    res_pos_next    = '0;
                end
                else
                begin
                    lo_next = '0;
                    hi_next = count_reg;
                end
            end
            ACT_BS_READ:
            begin
                if (!bs_more)
                begin
                    ptr_next = lo_reg;
                end
            end
            ACT_BS_CMP:
            begin
                if (bs_lt)
                begin
                    hi_next = CNT_W'(center);
                end
                else if (bs_gt)
                begin
                    lo_next = CNT_W'(center);
                end
                else
                begin
                    pos_next = CNT_W'(center);
                    ptr_next = count_reg;
                end
            end
            ACT_LIN_SCAN:
            begin
                if (lin_hit)
                begin
                    pos_next = CNT_W'(pend_addr_reg);
                    ptr_next = count_reg;
                end
                else if (lin_end)
                begin
                    pos_next = hi_reg;
                    ptr_next = count_reg;
                end
                else if (ptr_reg < hi_reg)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            ACT_INS_SHIFT:
            begin
                if (ptr_reg > pos_reg)
                begin
                    ptr_next = ptr_reg - CNT_W'(1);
                end
                if (ins_done)
                begin
                    count_next      = count_reg + CNT_W'(1);
                    res_status_next = ST_OK;
                    res_pos_next    = pos_reg;
                end
            end
            ACT_RD_START:
            begin
                if (rd_oob)
                begin
                    res_status_next = ST_OOB;
                    res_pos_next    = '0;
                end
            end
            ACT_RD_WAIT:
            begin
                res_status_next = ST_OK;
                res_pos_next    = CNT_W'(ridx_reg);
                res_id_next     = rd_data_reg.id;
                res_depth_next  = rd_data_reg.depth;
            end
            ACT_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pos_next    = res_pos_reg;
                    out_count_next  = count_reg;
                    out_id_next     = res_id_reg;
                    out_depth_next  = res_depth_reg;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        key_reg        <= key_next;
        ridx_reg       <= ridx_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        ptr_reg        <= ptr_next;
        pos_reg        <= pos_next;
        pend_addr_reg  <= pend_addr_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_id_reg     <= res_id_next;
        res_depth_reg  <= res_depth_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_count_reg  <= out_count_next;
        out_id_reg     <= out_id_next;
        out_depth_reg  <= out_depth_next;
    end

    // Channel outputs.
    assign req.ready       = cmd.in_ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.position    = POS_W'(out_pos_reg);
    assign rsp.entry_count = POS_W'(out_count_reg);
    assign rsp.read_id     = out_id_reg;
    assign rsp.read_depth  = out_depth_reg;

endmodule

// ----- src/dset_checker.sv -----
// Port-level checks for the depth-sorted entry table, bound to the top level.
// Depends on dset_pkg for the status codes and widths.
module dset_checker import dset_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_ready,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [STATUS_W-1:0]       rsp_status,
    input logic [POS_W-1:0]          rsp_position,
    input logic [POS_W-1:0]          rsp_entry_count,
    input logic [ID_W-1:0]           rsp_read_id,
    input logic signed [DEPTH_W-1:0] rsp_read_depth
);

    logic [POS_W-1:0] prev_count_reg;

    // Entry count of the last response transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_count_reg <= '0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            prev_count_reg <= rsp_entry_count;
        end
    end

    // A response stays offered until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before it was taken");

    // Only one request is in work at a time.
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in work");

    // Failed operations report position and read fields as zero.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |->
            (rsp_position == '0) && (rsp_read_id == '0) && (rsp_read_depth == '0))
        else $error("failed operation reports nonzero fields");

    // The count moves by at most one entry per transaction.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready |->
            (rsp_entry_count == prev_count_reg) ||
            (rsp_entry_count == prev_count_reg + POS_W'(1)) ||
            (rsp_entry_count + POS_W'(1) == prev_count_reg))
        else $error("entry count jumped by more than one");

endmodule

bind depth_sorted_entry_table_unit dset_checker u_dset_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_position    (rsp.position),
    .rsp_entry_count (rsp.entry_count),
    .rsp_read_id     (rsp.read_id),
    .rsp_read_depth  (rsp.read_depth)
);

// ----- tb/depth_sorted_entry_table_unit_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for depth_sorted_entry_table_unit: directed and random
// insert, remove, reposition and read transactions, checked against a local table.
// Depends on dset_pkg, the dset_in_if and dset_out_if interfaces and the block itself.
module depth_sorted_entry_table_unit_test;
    import dset_pkg::*;

    localparam int REQUEST_TARGET = 1950;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int DRAIN_CYCLES   = 800;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_GAP        = 19;

    typedef struct packed {
        op_t                       op;
        logic [ID_W-1:0]           id;
        logic signed [DEPTH_W-1:0] depth;
        logic [IDX_W-1:0]          idx;
    } table_request_t;

    typedef struct packed {
        status_t                   status;
        logic [POS_W-1:0]          position;
        logic [POS_W-1:0]          count;
        logic [ID_W-1:0]           id;
        logic signed [DEPTH_W-1:0] depth;
    } table_response_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dset_in_if  req_ch();
    dset_out_if rsp_ch();

    // Values driven onto the channels; known from time zero.
    table_request_t drv_req   = '0;
    logic           drv_valid = 1'b0;
    logic           mon_ready = 1'b0;

    assign req_ch.valid      = drv_valid;
    assign req_ch.operation  = drv_req.op;
    assign req_ch.item_id    = drv_req.id;
    assign req_ch.depth_key  = drv_req.depth;
    assign req_ch.read_index = drv_req.idx;
    assign rsp_ch.ready      = mon_ready;

    depth_sorted_entry_table_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Stimulus and expectation stores.
    table_request_t  pending_requests[$];
    table_response_t expected_responses[$];
    logic [ID_W-1:0] shadow_ids[$];

    // Predicted table contents.
    logic [ID_W-1:0]           tbl_ids [CAPACITY];
    logic signed [DEPTH_W-1:0] tbl_depths [CAPACITY];
    int                        tbl_count = 0;

    int requests_accepted = 0;
    int responses_seen    = 0;
    int mismatches        = 0;
    int peak_count        = 0;
    int idle_cycles       = 0;
    int op_counts [4]     = '{0, 0, 0, 0};
    int status_counts [4] = '{0, 0, 0, 0};
    logic req_taken = 1'b0;
    logic rsp_taken = 1'b0;
    int drv_gap     = 0;
    int stall_left  = 0;
    int hold_left   = 0;

    // Insert into the predicted table; returns the slot or -1 when full.
    function automatic int table_insert(input logic [ID_W-1:0] id,
                                        input logic signed [DEPTH_W-1:0] key);
        int lo, hi, mid, pos, i;
        bit hit;
        if (tbl_count >= CAPACITY)
            return -1;
        lo  = 0;
        hi  = tbl_count;
        pos = 0;
        hit = 1'b0;
        // Halve the range while it is wide; an equal center ends the search.
        while (hi - lo > LINEAR_STOP && !hit)
        begin
            mid = (lo + hi) >> 1;
            if (key < tbl_depths[mid])
                hi = mid;
            else if (key > tbl_depths[mid])
                lo = mid;
            else
            begin
                pos = mid;
                hit = 1'b1;
            end
        end
        // Linear scan for the first deeper entry.
        if (!hit)
        begin
            pos = lo;
            while (pos < hi && !(tbl_depths[pos] > key))
                pos++;
        end
        for (i = tbl_count; i > pos; i--)
        begin
            tbl_ids[i]    = tbl_ids[i-1];
            tbl_depths[i] = tbl_depths[i-1];
        end
        tbl_ids[pos]    = id;
        tbl_depths[pos] = key;
        tbl_count++;
        return pos;
    endfunction

    // Remove the first entry with the id; returns its slot or -1 when absent.
    function automatic int table_remove(input logic [ID_W-1:0] id);
        int pos, i;
        pos = 0;
        while (pos < tbl_count && tbl_ids[pos] != id)
            pos++;
        if (pos >= tbl_count)
            return -1;
        for (i = pos; i + 1 < tbl_count; i++)
        begin
            tbl_ids[i]    = tbl_ids[i+1];
            tbl_depths[i] = tbl_depths[i+1];
        end
        tbl_count--;
        return pos;
    endfunction

    // Apply one accepted request to the predicted table and form its response.
    function automatic table_response_t predict_response(input table_request_t rq);
        table_response_t rs;
        int slot;
        rs = '0;
        case (rq.op)
            OP_INSERT, OP_REPOSITION:
            begin
                if (rq.op == OP_REPOSITION)
                    slot = table_remove(rq.id);
                slot = table_insert(rq.id, rq.depth);
                if (slot < 0)
                    rs.status = ST_FULL;
                else
                    rs.position = slot[POS_W-1:0];
            end
            OP_REMOVE:
            begin
                slot = table_remove(rq.id);
                if (slot < 0)
                    rs.status = ST_NOT_FOUND;
                else
                    rs.position = slot[POS_W-1:0];
            end
            default:
            begin
                if (int'(rq.idx) >= tbl_count)
                    rs.status = ST_OOB;
                else
                begin
                    rs.position = POS_W'(rq.idx);
                    rs.id       = tbl_ids[rq.idx];
                    rs.depth    = tbl_depths[rq.idx];
                end
            end
        endcase
        rs.count = tbl_count[POS_W-1:0];
        return rs;
    endfunction

    // Position of an id in the stimulus-side id list, or -1.
    function automatic int shadow_find(input logic [ID_W-1:0] id);
        foreach (shadow_ids[i])
            if (shadow_ids[i] == id)
                return i;
        return -1;
    endfunction

    // Queue one request and track which ids the table will hold.
    task automatic queue_request(input op_t op, input logic [ID_W-1:0] id,
                                 input logic signed [DEPTH_W-1:0] depth,
                                 input logic [IDX_W-1:0] idx);
        table_request_t rq;
        int slot;
        rq.op    = op;
        rq.id    = id;
        rq.depth = depth;
        rq.idx   = idx;
        pending_requests.push_back(rq);
        if (op == OP_REMOVE || op == OP_REPOSITION)
        begin
            slot = shadow_find(id);
            if (slot >= 0)
                shadow_ids.delete(slot);
        end
        if ((op == OP_INSERT || op == OP_REPOSITION) && shadow_ids.size() < CAPACITY)
            shadow_ids.push_back(id);
    endtask

    // Ids come mostly from a small pool so that duplicates and hits are common.
    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return ID_W'($urandom);
        if (r < 10)
            return '0;
        if (r < 12)
            return '1;
        return ID_W'($urandom_range(0, 47));
    endfunction

    function automatic logic [ID_W-1:0] pick_held_id();
        if (shadow_ids.size() > 0 && $urandom_range(0, 99) < 85)
            return shadow_ids[$urandom_range(0, shadow_ids.size() - 1)];
        return pick_id();
    endfunction

    // Depths: a few half-unit steps around zero to force ties, extremes, and noise.
    function automatic logic signed [DEPTH_W-1:0] pick_depth();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return DEPTH_W'((int'($urandom_range(0, 12)) - 6) * 32768);
        if (r < 45)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sh0000_0000;
                default: return 32'shFFFF_FFFF;
            endcase
        end
        return DEPTH_W'($urandom);
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        if (shadow_ids.size() > 0 && $urandom_range(0, 99) < 80)
            return IDX_W'($urandom_range(0, shadow_ids.size() - 1));
        return IDX_W'($urandom_range(0, 255));
    endfunction

    // Clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stimulus generation, reset and end of run.
    initial
    begin
        int target, len, r, total_requests;
        bit grow;
        logic [ID_W-1:0] absent_id;

        // Empty table: a read and a remove both miss.
        queue_request(OP_READ,       16'h0000, 32'sh0000_0000, 8'd0);
        queue_request(OP_REMOVE,     16'h0005, 32'sh0000_0000, 8'd0);
        // Extremes of id and depth, a duplicate id with an equal depth.
        queue_request(OP_INSERT,     16'h0000, 32'sh0000_0000, 8'd0);
        queue_request(OP_INSERT,     16'hFFFF, 32'sh7FFF_FFFF, 8'hFF);
        queue_request(OP_INSERT,     16'h0001, 32'sh8000_0000, 8'd0);
        queue_request(OP_INSERT,     16'h0000, 32'sh0000_0000, 8'd0);
        // Reposition of an id that is not held still inserts it.
        queue_request(OP_REPOSITION, 16'h1234, 32'sh0001_0000, 8'd0);
        queue_request(OP_INSERT,     16'h0002, 32'sh0002_8000, 8'd0);
        queue_request(OP_INSERT,     16'h0003, 32'shFFFE_8000, 8'd0);
        queue_request(OP_INSERT,     16'h0004, 32'sh0001_0000, 8'd0);
        // With eight entries the first halving step lands on an equal depth.
        queue_request(OP_INSERT,     16'h0005, 32'sh0001_0000, 8'd0);
        queue_request(OP_READ,       16'h0000, 32'sh0000_0000, 8'd0);
        queue_request(OP_READ,       16'h0000, 32'sh0000_0000, 8'd8);
        queue_request(OP_READ,       16'h0000, 32'sh0000_0000, 8'd9);
        queue_request(OP_REPOSITION, 16'hFFFF, 32'sh8000_0000, 8'd0);
        queue_request(OP_REMOVE,     16'h0000, 32'sh0000_0000, 8'd0);
        queue_request(OP_REMOVE,     16'hFFFF, 32'sh0000_0000, 8'd0);
        queue_request(OP_READ,       16'h0000, 32'sh0000_0000, 8'hFF);
        queue_request(OP_INSERT,     16'hAAAA, 32'sh5555_5555, 8'hAA);
        queue_request(OP_INSERT,     16'h5555, 32'shAAAA_AAAA, 8'h55);
        queue_request(OP_READ,       16'h0000, 32'sh0000_0000, 8'd0);

        // Fill the table to capacity, then push against the full table.
        while (shadow_ids.size() < CAPACITY)
            queue_request(OP_INSERT, pick_id(), pick_depth(), IDX_W'($urandom));
        repeat (6)
            queue_request(OP_INSERT, pick_id(), pick_depth(), IDX_W'($urandom));
        repeat (3)
        begin
            do
                absent_id = ID_W'($urandom);
            while (shadow_find(absent_id) >= 0);
            queue_request(OP_REPOSITION, absent_id, pick_depth(), IDX_W'($urandom));
        end
        repeat (3)
            queue_request(OP_REPOSITION, pick_held_id(), pick_depth(), IDX_W'($urandom));
        repeat (4)
            queue_request(OP_READ, ID_W'($urandom), DEPTH_W'($urandom), pick_index());

        // Random episodes, each steering the occupancy toward its own level.
        while (pending_requests.size() < REQUEST_TARGET)
        begin
            target = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8)
                                                 : $urandom_range(0, CAPACITY);
            len = $urandom_range(20, 80);
            repeat (len)
            begin
                grow = shadow_ids.size() < target;
                r = $urandom_range(0, 99);
                if (r < (grow ? 50 : 10))
                    queue_request(OP_INSERT, pick_id(), pick_depth(), IDX_W'($urandom));
                else if (r < 60)
                    queue_request(OP_REMOVE, pick_held_id(), DEPTH_W'($urandom),
                                  IDX_W'($urandom));
                else if (r < 75)
                    queue_request(OP_REPOSITION, pick_held_id(), pick_depth(),
                                  IDX_W'($urandom));
                else
                    queue_request(OP_READ, ID_W'($urandom), DEPTH_W'($urandom),
                                  pick_index());
            end
        end
        total_requests = pending_requests.size();

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (requests_accepted < total_requests || expected_responses.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d transactions: %0d insert, %0d remove, %0d reposition, %0d read; peak occupancy %0d of %0d.",
                 requests_accepted, op_counts[OP_INSERT], op_counts[OP_REMOVE],
                 op_counts[OP_REPOSITION], op_counts[OP_READ], peak_count, CAPACITY);
        $display("Responses: %0d ok, %0d full, %0d id absent, %0d index out of range; %0d mismatches.",
                 status_counts[ST_OK], status_counts[ST_FULL], status_counts[ST_NOT_FOUND],
                 status_counts[ST_OOB], mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Request driver: offers queued requests with random gaps between them.
    always @(negedge clk)
    begin : drive_requests
        int gap;
        bit quiet;
        gap   = drv_gap;
        quiet = ((requests_accepted / 64) % 5) == 4;
        if (rst_n && (!drv_valid || req_taken))
        begin
            if (req_taken)
                gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0 || pending_requests.size() == 0)
            begin
                drv_valid <= 1'b0;
                if (gap > 0)
                    gap--;
            end
            else
            begin
                drv_req   <= pending_requests.pop_front();
                drv_valid <= 1'b1;
            end
        end
        drv_gap <= gap;
    end

    // Response pacing: random stalls, quiet stretches and two long hold-offs.
    always @(negedge clk)
    begin : pace_responses
        int stall, hold;
        bit quiet;
        stall = stall_left;
        hold  = hold_left;
        quiet = ((responses_seen / 64) % 5) == 2;
        if (rst_n)
        begin
            if (rsp_taken)
            begin
                stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
                if (responses_seen == 50 || responses_seen == 1100)
                    hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                mon_ready <= 1'b0;
                hold--;
            end
            else if (stall > 0)
            begin
                mon_ready <= 1'b0;
                stall--;
            end
            else
                mon_ready <= 1'b1;
        end
        stall_left <= stall;
        hold_left  <= hold;
    end

    // Predict on each accepted request and check each accepted response.
    always @(posedge clk or negedge rst_n)
    begin : predict_and_check
        table_response_t want;
        if (!rst_n)
        begin
            req_taken <= 1'b0;
            rsp_taken <= 1'b0;
        end
        else
        begin
            req_taken <= drv_valid && req_ch.ready;
            rsp_taken <= rsp_ch.valid && mon_ready;
            if (drv_valid && req_ch.ready)
            begin
                want = predict_response(drv_req);
                expected_responses.push_back(want);
                op_counts[drv_req.op]++;
                if (tbl_count > peak_count)
                    peak_count = tbl_count;
                requests_accepted <= requests_accepted + 1;
            end
            if (rsp_ch.valid && mon_ready)
            begin
                responses_seen <= responses_seen + 1;
                if (expected_responses.size() == 0)
                begin
                    $display("%0t: response with none expected, status %0d position %0d",
                             $time, rsp_ch.status, rsp_ch.position);
                    mismatches++;
                end
                else
                begin
                    want = expected_responses.pop_front();
                    status_counts[want.status]++;
                    if (rsp_ch.status !== want.status)
                    begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, rsp_ch.status);
                        mismatches++;
                    end
                    if (rsp_ch.position !== want.position)
                    begin
                        $display("%0t: position expected %0d, actual %0d",
                                 $time, want.position, rsp_ch.position);
                        mismatches++;
                    end
                    if (rsp_ch.entry_count !== want.count)
                    begin
                        $display("%0t: entry_count expected %0d, actual %0d",
                                 $time, want.count, rsp_ch.entry_count);
                        mismatches++;
                    end
                    if (rsp_ch.read_id !== want.id)
                    begin
                        $display("%0t: read_id expected %h, actual %h",
                                 $time, want.id, rsp_ch.read_id);
                        mismatches++;
                    end
                    if (rsp_ch.read_depth !== want.depth)
                    begin
                        $display("%0t: read_depth expected %h, actual %h",
                                 $time, want.depth, rsp_ch.read_depth);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (drv_valid && req_ch.ready) || (rsp_ch.valid && mon_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
